// File: sv/fbw_pkg.sv
// Package for the flash byte writer: command codes, configuration indexes,
// queue entry type, constants and the sector lookup. No dependencies.
`timescale 1ns / 1ps

package fbw_pkg;

    localparam int unsigned MAX_TRANSFER_BYTES = 1048576;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned LEN_W = 21;
    localparam int unsigned CFG_W = 28;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] USER_START_RST = 28'h8020000;
    localparam logic [CFG_W-1:0] FLASH_END_RST = 28'h8100000;
    localparam logic [31:0] WORD_ERASED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_ERASE   = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        CFG_USER_START = 1'b0,
        CFG_FLASH_END  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic        reject;
        logic        erase;
        logic        prog;
        logic        done;
        logic [3:0]  sector;
        logic [31:0] waddr;
        logic [31:0] wdata;
    } t_entry;

    function automatic logic [3:0] sector_of(input logic [31:0] a);
        logic [14:0] d;
        d = a[31:17] - 15'h0402;
        if (a < 32'h0800_4000) return 4'd0;
        if (a < 32'h0800_8000) return 4'd1;
        if (a < 32'h0800_C000) return 4'd2;
        if (a < 32'h0801_0000) return 4'd3;
        if (a < 32'h0802_0000) return 4'd4;
        if (a < 32'h0804_0000) return 4'd5;
        if (a >= 32'h080E_0000) return 4'd11;
        return 4'd6 + {1'b0, d[2:0]};
    endfunction

endpackage

// File: sv/fbw_in_if.sv
// Input channel of the flash byte writer: valid, ready and one data byte item.
// Depends on nothing.
`timescale 1ns / 1ps

interface fbw_in_if;
    logic        valid;
    logic        ready;
    logic        begins_transfer;
    logic [31:0] start_address;
    logic [20:0] transfer_length;
    logic [7:0]  data_byte;

    modport source (
        output valid, begins_transfer, start_address, transfer_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, begins_transfer, start_address, transfer_length, data_byte,
        output ready
    );
endinterface

// File: sv/fbw_out_if.sv
// Output channel of the flash byte writer: valid, ready and one flash command.
// Depends on nothing.
`timescale 1ns / 1ps

interface fbw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command_kind;
    logic [3:0]  sector_number;
    logic [31:0] word_address;
    logic [31:0] word_data;
    logic        final_of_run;

    modport source (
        output valid, command_kind, sector_number, word_address, word_data, final_of_run,
        input  ready
    );
    modport sink (
        input  valid, command_kind, sector_number, word_address, word_data, final_of_run,
        output ready
    );
endinterface

// File: sv/flash_byte_writer_auto_erase.sv
// Flash byte writer with sector auto-erase: one byte item accepted per cycle
// while the four-entry command queue has room; commands leave at one per cycle
// while the sink is ready. An item yields up to three commands, so the output
// rate sets the sustained throughput. Synchronous active-low reset clears the
// control state but not the queue memory or output data, and restores both
// window registers. Depends on fbw_pkg and the interfaces.
`timescale 1ns / 1ps

module flash_byte_writer_auto_erase (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  fbw_pkg::t_cfg_index        i_cfg_index,
    input  logic [fbw_pkg::CFG_W-1:0]  i_cfg_data,
    fbw_in_if.sink                     i_item,
    fbw_out_if.source                  o_cmd
);
    import fbw_pkg::*;

    t_entry push;
    logic   push_valid;
    logic   full;
    logic   pop;
    logic   nonempty;
    t_entry head;

    fbw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (i_item),
        .i_full       (full),
        .o_push       (push),
        .o_push_valid (push_valid)
    );

    fbw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_valid (push_valid),
        .o_full       (full),
        .i_pop        (pop),
        .o_nonempty   (nonempty),
        .o_head       (head)
    );

    fbw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_cmd      (o_cmd)
    );

endmodule

// File: sv/fbw_front.sv
// Front end: holds configuration and transfer state, checks transfers, packs
// bytes into words and decides erases. Depends on fbw_pkg and fbw_in_if.
`timescale 1ns / 1ps

module fbw_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  fbw_pkg::t_cfg_index        i_cfg_index,
    input  logic [fbw_pkg::CFG_W-1:0]  i_cfg_data,
    fbw_in_if.sink                     i_item,
    input  logic                       i_full,
    output fbw_pkg::t_entry            o_push,
    output logic                       o_push_valid
);
    import fbw_pkg::*;

    logic [CFG_W-1:0] r_user_start, n_user_start;
    logic [CFG_W-1:0] r_flash_end, n_flash_end;
    logic             r_active, n_active;
    logic             r_dropping, n_dropping;
    logic [31:0]      r_nba, n_nba;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [31:0]      r_word, n_word;
    logic [3:0]       r_ers_sec, n_ers_sec;
    logic             r_ers_valid, n_ers_valid;

    logic             accept;
    logic             bad;
    logic             take;
    logic [31:0]      cur_nba;
    logic [LEN_W-1:0] cur_rem;
    logic [31:0]      cur_word;
    logic [3:0]       cur_sec;
    logic             cur_valid;
    logic [1:0]       lane;
    logic [31:0]      new_word;
    logic [LEN_W-1:0] rem_new;
    logic             word_done;
    logic [3:0]       sec;
    logic [32:0]      end_sum;

    assign i_item.ready = !i_full;
    assign accept = i_item.valid && !i_full;

    assign end_sum = {1'b0, i_item.start_address} + 33'(i_item.transfer_length);
    assign bad = (i_item.transfer_length == '0)
              || (32'(i_item.transfer_length) > 32'(MAX_TRANSFER_BYTES))
              || (i_item.start_address < 32'(r_user_start))
              || (i_item.start_address >= 32'(r_flash_end))
              || (end_sum > 33'(r_flash_end));

    assign cur_nba   = i_item.begins_transfer ? i_item.start_address : r_nba;
    assign cur_rem   = i_item.begins_transfer ? i_item.transfer_length : r_rem;
    assign cur_word  = i_item.begins_transfer ? WORD_ERASED : r_word;
    assign cur_sec   = i_item.begins_transfer ? 4'd0 : r_ers_sec;
    assign cur_valid = i_item.begins_transfer ? 1'b0 : r_ers_valid;

    assign take = accept && (i_item.begins_transfer ? !bad : (r_active && !r_dropping));
    assign lane = cur_nba[1:0];
    assign rem_new = (cur_rem != '0) ? cur_rem - LEN_W'(1) : cur_rem;
    assign word_done = (lane == 2'd3) || (rem_new == '0);
    assign sec = sector_of({cur_nba[31:2], 2'b00});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            new_word[8*k +: 8] = (lane == 2'(k)) ? i_item.data_byte : cur_word[8*k +: 8];
        end
    end

    always_comb begin
        n_user_start = r_user_start;
        n_flash_end  = r_flash_end;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_USER_START: n_user_start = i_cfg_data;
                CFG_FLASH_END:  n_flash_end = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_active    = r_active;
        n_dropping  = r_dropping;
        n_nba       = r_nba;
        n_rem       = r_rem;
        n_word      = r_word;
        n_ers_sec   = r_ers_sec;
        n_ers_valid = r_ers_valid;
        o_push      = '0;
        o_push_valid = 1'b0;
        if (accept && i_item.begins_transfer) begin
            n_word      = WORD_ERASED;
            n_ers_sec   = 4'd0;
            n_ers_valid = 1'b0;
            if (bad) begin
                n_active     = 1'b0;
                n_dropping   = 1'b1;
                n_rem        = '0;
                o_push.reject = 1'b1;
                o_push_valid = 1'b1;
            end else begin
                n_active   = 1'b1;
                n_dropping = 1'b0;
            end
        end
        if (take) begin
            n_nba  = cur_nba + 32'd1;
            n_rem  = rem_new;
            n_word = new_word;
            if (word_done) begin
                o_push_valid   = 1'b1;
                o_push.erase   = !cur_valid || (sec != cur_sec);
                o_push.sector  = sec;
                o_push.prog    = 1'b1;
                o_push.waddr   = {cur_nba[31:2], 2'b00};
                o_push.wdata   = new_word;
                n_ers_sec      = sec;
                n_ers_valid    = 1'b1;
                n_word         = WORD_ERASED;
                if (rem_new == '0) begin
                    o_push.done = 1'b1;
                    n_active    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_start <= USER_START_RST;
            r_flash_end  <= FLASH_END_RST;
            r_active     <= 1'b0;
            r_dropping   <= 1'b0;
            r_nba        <= '0;
            r_rem        <= '0;
            r_word       <= WORD_ERASED;
            r_ers_sec    <= 4'd0;
            r_ers_valid  <= 1'b0;
        end else begin
            r_user_start <= n_user_start;
            r_flash_end  <= n_flash_end;
            r_active     <= n_active;
            r_dropping   <= n_dropping;
            r_nba        <= n_nba;
            r_rem        <= n_rem;
            r_word       <= n_word;
            r_ers_sec    <= n_ers_sec;
            r_ers_valid  <= n_ers_valid;
        end
    end

endmodule

// File: sv/fbw_queue.sv
// Short first-in first-out queue of command groups between front and back end.
// Depends on fbw_pkg.
`timescale 1ns / 1ps

module fbw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fbw_pkg::t_entry i_push,
    input  logic            i_push_valid,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output fbw_pkg::t_entry o_head
);
    import fbw_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QPTR_W:0]     r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rptr];
    assign do_push    = i_push_valid && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push;
        end
    end

endmodule

// File: sv/fbw_back.sv
// Back end: expands each command group into erase, program, done or reject
// transfers through an output register. Depends on fbw_pkg and fbw_out_if.
`timescale 1ns / 1ps

module fbw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  fbw_pkg::t_entry i_head,
    output logic            o_pop,
    fbw_out_if.source       o_cmd
);
    import fbw_pkg::*;

    t_entry      r_ent, n_ent;
    logic        r_out_valid, n_out_valid;
    t_kind       r_kind, n_kind;
    logic [3:0]  r_sec, n_sec;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_data, n_data;
    logic        r_final, n_final;

    logic        can_emit;
    logic        busy;
    logic        emit;
    t_entry      left;

    assign can_emit = !r_out_valid || o_cmd.ready;
    assign busy = r_ent.reject || r_ent.erase || r_ent.prog || r_ent.done;
    assign emit = busy && can_emit;

    always_comb begin
        left = r_ent;
        n_kind = r_kind;
        n_sec  = r_sec;
        n_addr = r_addr;
        n_data = r_data;
        if (emit) begin
            n_sec  = 4'd0;
            n_addr = '0;
            n_data = '0;
            if (r_ent.reject) begin
                n_kind = KIND_REJECT;
                left.reject = 1'b0;
            end else if (r_ent.erase) begin
                n_kind = KIND_ERASE;
                n_sec  = r_ent.sector;
                left.erase = 1'b0;
            end else if (r_ent.prog) begin
                n_kind = KIND_PROGRAM;
                n_addr = r_ent.waddr;
                n_data = r_ent.wdata;
                left.prog = 1'b0;
            end else begin
                n_kind = KIND_DONE;
                left.done = 1'b0;
            end
        end
        n_final = !(left.reject || left.erase || left.prog || left.done);
        o_pop = i_nonempty && n_final;
        n_ent = o_pop ? i_head : left;
        n_out_valid = can_emit ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ent       <= n_ent;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= n_kind;
            r_sec   <= n_sec;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_final <= n_final;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.command_kind  = r_kind;
    assign o_cmd.sector_number = r_sec;
    assign o_cmd.word_address  = r_addr;
    assign o_cmd.word_data     = r_data;
    assign o_cmd.final_of_run  = r_final;

endmodule
